@@ hdl/hcid_pkg.sv @@
// Shared types and constants for the HCI serial frame deframer.
`default_nettype none

package hcid_pkg;

    // Receive phases, one per byte position in a frame
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TYPE_HI,
        PH_TYPE_LO,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_CHECK,
        PH_PAYLOAD,
        PH_END
    } phase_t;

    // Result item kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD,
        KIND_ACCEPT,
        KIND_DROP,
        KIND_ACK
    } kind_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_BYTE = 2'd0;
    localparam logic [1:0] CFG_END_BYTE   = 2'd1;
    localparam logic [1:0] CFG_ACK_TYPE   = 2'd2;

    // Register reset values
    localparam logic [7:0]  START_BYTE_RST = 8'h55;
    localparam logic [7:0]  END_BYTE_RST   = 8'hAA;
    localparam logic [15:0] ACK_TYPE_RST   = 16'h8000;

    // Payload bytes of an acknowledge frame that are kept
    localparam logic [1:0] ACK_IDX_TYPE_HI = 2'd0;
    localparam logic [1:0] ACK_IDX_TYPE_LO = 2'd1;
    localparam logic [1:0] ACK_IDX_STATUS  = 2'd2;
    localparam logic [1:0] ACK_IDX_REST    = 2'd3;

endpackage

`default_nettype wire

@@ hdl/hci_uart_frame_deframer.sv @@
// Top level of the HCI serial frame deframer: byte FSM and result register.
//
// Usage: received serial bytes enter on the s_ channel (s_valid/s_ready,
// payload s_rx_byte), one item per byte. The block hunts for the start
// byte, then reads a big-endian type, a big-endian length, a check byte,
// the payload and an end byte. Results leave on the m_ channel
// (m_valid/m_ready): one item per payload byte of a non-acknowledge frame,
// and one final item per frame (accepted, dropped on a bad end byte, or
// acknowledge with its request type and status). Header bytes give none.
// A result is registered and shown in the cycle after its byte is accepted.
// Throughput: one byte per cycle while m_ready is high; the single result
// register sets that figure, and s_ready is high whenever that register is
// empty or being emptied in the same cycle.
// Receiver stall: a waiting result holds m_* stable and s_ready drops.
// Reset (aresetn low, synchronous): the block returns to hunting, the
// result register empties and the delimiter and acknowledge type
// registers return to 0x55, 0xAA and 0x8000.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_addr
// (0 start byte, 1 end byte, 2 acknowledge type) at once; write while idle.
`default_nettype none

module hci_uart_frame_deframer #(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    // received bytes
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    // result items
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [15:0]      m_frame_kind_code,
    output logic [7:0]       m_data_byte,
    output logic [15:0]      m_ack_request_type,
    output logic [7:0]       m_ack_status,
    output logic             m_check_ok,
    output logic             m_frame_end
);

    // configuration registers
    logic [7:0]  start_byte_reg;
    logic [7:0]  end_byte_reg;
    logic [15:0] ack_type_reg;

    // frame state
    hcid_pkg::phase_t       phase_reg, phase_next;
    logic [15:0]            frame_type_reg, frame_type_next;
    logic [7:0]             len_hi_reg, len_hi_next;
    logic [LENGTH_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [1:0]             idx_reg, idx_next;
    logic [7:0]             check_rx_reg, check_rx_next;
    logic [7:0]             check_run_reg, check_run_next;
    logic [15:0]            ack_cap_type_reg, ack_cap_type_next;
    logic [7:0]             ack_cap_status_reg, ack_cap_status_next;

    // result register
    logic                   out_valid_reg;
    hcid_pkg::kind_t        out_kind_reg;
    logic [15:0]            out_type_reg;
    logic [7:0]             out_data_reg;
    logic [15:0]            out_rq_reg;
    logic [7:0]             out_st_reg;
    logic                   out_ok_reg;
    logic                   out_fin_reg;

    // result of the byte being accepted
    logic                   res_valid;
    hcid_pkg::kind_t        res_kind;
    logic [7:0]             res_data;
    logic [15:0]            res_rq;
    logic [7:0]             res_st;
    logic                   res_ok;
    logic                   res_fin;

    logic                   in_fire;
    logic                   is_ack;
    logic [15:0]            len_full;

    assign s_ready  = !out_valid_reg || m_ready;
    assign in_fire  = s_valid && s_ready;
    assign is_ack   = (frame_type_reg == ack_type_reg);
    assign len_full = {len_hi_reg, s_rx_byte};

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= hcid_pkg::START_BYTE_RST;
            end_byte_reg   <= hcid_pkg::END_BYTE_RST;
            ack_type_reg   <= hcid_pkg::ACK_TYPE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                hcid_pkg::CFG_START_BYTE: start_byte_reg <= cfg_wdata[7:0];
                hcid_pkg::CFG_END_BYTE:   end_byte_reg   <= cfg_wdata[7:0];
                hcid_pkg::CFG_ACK_TYPE:   ack_type_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (in_fire) begin
            unique case (phase_reg)
                hcid_pkg::PH_HUNT:
                    if (s_rx_byte == start_byte_reg) phase_next = hcid_pkg::PH_TYPE_HI;
                hcid_pkg::PH_TYPE_HI: phase_next = hcid_pkg::PH_TYPE_LO;
                hcid_pkg::PH_TYPE_LO: phase_next = hcid_pkg::PH_LEN_HI;
                hcid_pkg::PH_LEN_HI:  phase_next = hcid_pkg::PH_LEN_LO;
                hcid_pkg::PH_LEN_LO:  phase_next = hcid_pkg::PH_CHECK;
                hcid_pkg::PH_CHECK:
                    phase_next = (bytes_left_reg == '0) ? hcid_pkg::PH_END
                                                        : hcid_pkg::PH_PAYLOAD;
                hcid_pkg::PH_PAYLOAD:
                    if (bytes_left_reg == LENGTH_BITS'(1)) phase_next = hcid_pkg::PH_END;
                hcid_pkg::PH_END:     phase_next = hcid_pkg::PH_HUNT;
                default:              phase_next = hcid_pkg::PH_HUNT;
            endcase
        end
    end

    // frame fields, check and result per phase
    always_comb begin
        frame_type_next     = frame_type_reg;
        len_hi_next         = len_hi_reg;
        bytes_left_next     = bytes_left_reg;
        idx_next            = idx_reg;
        check_rx_next       = check_rx_reg;
        check_run_next      = check_run_reg;
        ack_cap_type_next   = ack_cap_type_reg;
        ack_cap_status_next = ack_cap_status_reg;
        res_valid           = 1'b0;
        res_kind            = hcid_pkg::KIND_PAYLOAD;
        res_data            = '0;
        res_rq              = '0;
        res_st              = '0;
        res_ok              = 1'b0;
        res_fin             = 1'b0;
        if (in_fire) begin
            unique case (phase_reg)
                hcid_pkg::PH_HUNT:
                    if (s_rx_byte == start_byte_reg) begin
                        frame_type_next     = '0;
                        len_hi_next         = '0;
                        bytes_left_next     = '0;
                        idx_next            = hcid_pkg::ACK_IDX_TYPE_HI;
                        check_rx_next       = '0;
                        check_run_next      = '0;
                        ack_cap_type_next   = '0;
                        ack_cap_status_next = '0;
                    end
                hcid_pkg::PH_TYPE_HI: begin
                    frame_type_next = {s_rx_byte, 8'h00};
                    check_run_next  = check_run_reg ^ s_rx_byte;
                end
                hcid_pkg::PH_TYPE_LO: begin
                    frame_type_next = {frame_type_reg[15:8], s_rx_byte};
                    check_run_next  = check_run_reg ^ s_rx_byte;
                end
                hcid_pkg::PH_LEN_HI: begin
                    len_hi_next    = s_rx_byte;
                    check_run_next = check_run_reg ^ s_rx_byte;
                end
                hcid_pkg::PH_LEN_LO: begin
                    // length bits above the counter width are dropped
                    bytes_left_next = len_full[LENGTH_BITS-1:0];
                    check_run_next  = check_run_reg ^ s_rx_byte;
                end
                hcid_pkg::PH_CHECK:
                    check_rx_next = s_rx_byte;
                hcid_pkg::PH_PAYLOAD: begin
                    check_run_next  = check_run_reg ^ s_rx_byte;
                    bytes_left_next = bytes_left_reg - LENGTH_BITS'(1);
                    case (idx_reg)
                        hcid_pkg::ACK_IDX_TYPE_HI:
                            ack_cap_type_next = {s_rx_byte, ack_cap_type_reg[7:0]};
                        hcid_pkg::ACK_IDX_TYPE_LO:
                            ack_cap_type_next = {ack_cap_type_reg[15:8], s_rx_byte};
                        hcid_pkg::ACK_IDX_STATUS:
                            ack_cap_status_next = s_rx_byte;
                        default: ;
                    endcase
                    // byte index saturates once the kept bytes are past
                    if (idx_reg != hcid_pkg::ACK_IDX_REST) idx_next = idx_reg + 2'd1;
                    if (!is_ack) begin
                        res_valid = 1'b1;
                        res_kind  = hcid_pkg::KIND_PAYLOAD;
                        res_data  = s_rx_byte;
                    end
                end
                hcid_pkg::PH_END: begin
                    res_valid = 1'b1;
                    res_ok    = (check_run_reg == check_rx_reg);
                    res_fin   = 1'b1;
                    if (s_rx_byte != end_byte_reg) begin
                        res_kind = hcid_pkg::KIND_DROP;
                    end else if (is_ack) begin
                        res_kind = hcid_pkg::KIND_ACK;
                        res_rq   = ack_cap_type_reg;
                        res_st   = ack_cap_status_reg;
                    end else begin
                        res_kind = hcid_pkg::KIND_ACCEPT;
                    end
                end
                default: ;
            endcase
        end
    end

    // frame state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= hcid_pkg::PH_HUNT;
        end else begin
            phase_reg <= phase_next;
        end
        frame_type_reg     <= frame_type_next;
        len_hi_reg         <= len_hi_next;
        bytes_left_reg     <= bytes_left_next;
        idx_reg            <= idx_next;
        check_rx_reg       <= check_rx_next;
        check_run_reg      <= check_run_next;
        ack_cap_type_reg   <= ack_cap_type_next;
        ack_cap_status_reg <= ack_cap_status_next;
    end

    // result register: loads on a new result, empties when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_fire && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (in_fire && res_valid) begin
            out_kind_reg <= res_kind;
            out_type_reg <= frame_type_reg;
            out_data_reg <= res_data;
            out_rq_reg   <= res_rq;
            out_st_reg   <= res_st;
            out_ok_reg   <= res_ok;
            out_fin_reg  <= res_fin;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_kind             = out_kind_reg;
    assign m_frame_kind_code  = out_type_reg;
    assign m_data_byte        = out_data_reg;
    assign m_ack_request_type = out_rq_reg;
    assign m_ack_status       = out_st_reg;
    assign m_check_ok         = out_ok_reg;
    assign m_frame_end        = out_fin_reg;

endmodule

`default_nettype wire

@@ bench/tb_hci_uart_frame_deframer.sv @@
// Testbench for the HCI serial frame deframer: byte streams in, predicted results checked out.
`default_nettype none

module tb_hci_uart_frame_deframer;

    localparam int          LEN_BITS      = 16;
    localparam logic [15:0] LEN_MASK      = 16'((32'd1 << LEN_BITS) - 1);
    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          RANDOM_BYTES  = 360;
    localparam int          RANDOM_PHASES = 4;

    // One expected result item
    typedef struct packed {
        hcid_pkg::kind_t kind;
        logic [15:0]     frame_kind_code;
        logic [7:0]      data_byte;
        logic [15:0]     ack_request_type;
        logic [7:0]      ack_status;
        logic            check_ok;
        logic            frame_end;
    } deframe_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_kind;
    logic [15:0] m_frame_kind_code;
    logic [7:0]  m_data_byte;
    logic [15:0] m_ack_request_type;
    logic [7:0]  m_ack_status;
    logic        m_check_ok;
    logic        m_frame_end;

    // Register copies
    logic [7:0]  start_val;
    logic [7:0]  end_val;
    logic [15:0] ack_type_val;

    // Deframer state as predicted
    hcid_pkg::phase_t rx_phase;
    logic [15:0]      rx_type;
    logic [15:0]      rx_len;
    logic [15:0]      rx_left;
    logic [7:0]       rx_check;
    logic [7:0]       xor_sum;
    logic [15:0]      ack_type_seen;
    logic [7:0]       ack_status_seen;

    deframe_result_t pending_results[$];
    int unsigned     error_count;
    int unsigned     cycle_count;
    int unsigned     sent_count;
    int              hold_off_left;
    bit              idle_on;

    hci_uart_frame_deframer dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_rx_byte          (s_rx_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_frame_kind_code  (m_frame_kind_code),
        .m_data_byte        (m_data_byte),
        .m_ack_request_type (m_ack_request_type),
        .m_ack_status       (m_ack_status),
        .m_check_ok         (m_check_ok),
        .m_frame_end        (m_frame_end)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_hci_uart_frame_deframer NOT OK");
            $finish;
        end
    end

    // Registers and frame state after reset
    function automatic void clear_model();
        start_val       = hcid_pkg::START_BYTE_RST;
        end_val         = hcid_pkg::END_BYTE_RST;
        ack_type_val    = hcid_pkg::ACK_TYPE_RST;
        rx_phase        = hcid_pkg::PH_HUNT;
        rx_type         = '0;
        rx_len          = '0;
        rx_left         = '0;
        rx_check        = '0;
        xor_sum         = '0;
        ack_type_seen   = '0;
        ack_status_seen = '0;
    endfunction

    // Append one prediction to the expected queue
    function automatic void expect_result(input deframe_result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Advance the frame state by one accepted byte, queue any result it gives
    function automatic void deframe_byte(input logic [7:0] b);
        logic            is_ack;
        logic [15:0]     idx;
        deframe_result_t r;
        is_ack = (rx_type == ack_type_val);
        r = '0;
        r.frame_kind_code = rx_type;
        case (rx_phase)
            hcid_pkg::PH_HUNT: begin
                if (b == start_val) begin
                    rx_type         = '0;
                    rx_len          = '0;
                    rx_left         = '0;
                    rx_check        = '0;
                    xor_sum         = '0;
                    ack_type_seen   = '0;
                    ack_status_seen = '0;
                    rx_phase        = hcid_pkg::PH_TYPE_HI;
                end
            end
            hcid_pkg::PH_TYPE_HI: begin
                rx_type  = {b, 8'h00};
                xor_sum ^= b;
                rx_phase = hcid_pkg::PH_TYPE_LO;
            end
            hcid_pkg::PH_TYPE_LO: begin
                rx_type[7:0] = b;
                xor_sum     ^= b;
                rx_phase     = hcid_pkg::PH_LEN_HI;
            end
            hcid_pkg::PH_LEN_HI: begin
                rx_len   = {b, 8'h00};
                xor_sum ^= b;
                rx_phase = hcid_pkg::PH_LEN_LO;
            end
            hcid_pkg::PH_LEN_LO: begin
                rx_len   = {rx_len[15:8], b} & LEN_MASK;
                rx_left  = rx_len;
                xor_sum ^= b;
                rx_phase = hcid_pkg::PH_CHECK;
            end
            hcid_pkg::PH_CHECK: begin
                rx_check = b;
                rx_phase = (rx_left == 0) ? hcid_pkg::PH_END : hcid_pkg::PH_PAYLOAD;
            end
            hcid_pkg::PH_PAYLOAD: begin
                idx      = rx_len - rx_left;
                xor_sum ^= b;
                if (idx == 16'(hcid_pkg::ACK_IDX_TYPE_HI))
                    ack_type_seen[15:8] = b;
                else if (idx == 16'(hcid_pkg::ACK_IDX_TYPE_LO))
                    ack_type_seen[7:0] = b;
                else if (idx == 16'(hcid_pkg::ACK_IDX_STATUS))
                    ack_status_seen = b;
                rx_left = rx_left - 1'b1;
                if (rx_left == 0)
                    rx_phase = hcid_pkg::PH_END;
                if (!is_ack) begin
                    r.kind      = hcid_pkg::KIND_PAYLOAD;
                    r.data_byte = b;
                    expect_result(r);
                end
            end
            default: begin
                r.check_ok  = (xor_sum == rx_check);
                r.frame_end = 1'b1;
                rx_phase    = hcid_pkg::PH_HUNT;
                if (b != end_val) begin
                    r.kind = hcid_pkg::KIND_DROP;
                end else if (is_ack) begin
                    r.kind             = hcid_pkg::KIND_ACK;
                    r.ack_request_type = ack_type_seen;
                    r.ack_status       = ack_status_seen;
                end else begin
                    r.kind = hcid_pkg::KIND_ACCEPT;
                end
                expect_result(r);
            end
        endcase
    endfunction

    // Offer one byte, with an occasional gap first, and predict on acceptance
    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        deframe_byte(b);
        sent_count++;
    endtask

    // Stop offering and let every expected result come out
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write; call only while idle
    task automatic write_reg(input logic [1:0] addr, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            hcid_pkg::CFG_START_BYTE: start_val    = value[7:0];
            hcid_pkg::CFG_END_BYTE:   end_val      = value[7:0];
            hcid_pkg::CFG_ACK_TYPE:   ack_type_val = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == start_val)
            b = ~b;
        return b;
    endfunction

    function automatic logic [7:0] wrong_end();
        return end_val ^ 8'($urandom_range(1, 255));
    endfunction

    // Whole frame; body must hold flen bytes
    task automatic send_frame(input logic [15:0] ftype, input logic [15:0] flen,
                              input logic [7:0] body[$], input logic bad_check,
                              input logic [7:0] closing);
        logic [7:0] chk;
        chk = ftype[15:8] ^ ftype[7:0] ^ flen[15:8] ^ flen[7:0];
        foreach (body[i]) chk ^= body[i];
        if (bad_check)
            chk ^= 8'(1 << $urandom_range(0, 7));
        send_byte(start_val);
        send_byte(ftype[15:8]);
        send_byte(ftype[7:0]);
        send_byte(flen[15:8]);
        send_byte(flen[7:0]);
        send_byte(chk);
        foreach (body[i]) send_byte(body[i]);
        send_byte(closing);
    endtask

    // Mostly short frames, a third of them acknowledges, some broken
    task automatic send_random_frame(input int max_len);
        logic [7:0]  body[$];
        logic [15:0] ftype;
        int          n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, max_len) : $urandom_range(0, 6);
        ftype = ($urandom_range(0, 2) == 0) ? ack_type_val : 16'($urandom);
        repeat (n) body.insert(body.size(), 8'($urandom));
        send_frame(ftype, 16'(n), body, $urandom_range(0, 4) == 0,
                   ($urandom_range(0, 4) == 0) ? wrong_end() : end_val);
    endtask

    // Field extremes, every result kind and the header/short/empty/bad-end cases
    task automatic test_directed();
        logic [7:0] body[$];
        // bytes while hunting give nothing
        send_byte(8'h00);
        send_byte(8'hFF);
        // empty data frame with all-ones type
        send_frame(16'hFFFF, 16'h0000, body, 1'b0, end_val);
        // short acknowledge: status byte never arrives
        body.insert(body.size(), 8'hFF);
        body.insert(body.size(), 8'h00);
        send_frame(hcid_pkg::ACK_TYPE_RST, 16'd2, body, 1'b0, end_val);
        // bad check and a closing byte equal to the start byte
        body.delete();
        body.insert(body.size(), 8'h00);
        send_frame(16'h0000, 16'd1, body, 1'b1, start_val);
        // hunting again: this byte opens nothing
        send_byte(8'h7E);
        wait_idle();
    endtask

    // Acknowledge type and end byte changed while the frame waits for its end
    task automatic test_mid_frame_writes();
        logic [7:0] chk;
        chk = 8'h12 ^ 8'h34 ^ 8'h00 ^ 8'h03 ^ 8'hC0 ^ 8'hDE ^ 8'h5A;
        send_byte(start_val);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h00);
        send_byte(8'h03);
        send_byte(chk);
        send_byte(8'hC0);
        send_byte(8'hDE);
        send_byte(8'h5A);
        wait_idle();
        write_reg(hcid_pkg::CFG_ACK_TYPE, 16'h1234);
        write_reg(hcid_pkg::CFG_END_BYTE, 16'h003C);
        send_byte(end_val);
        wait_idle();
    endtask

    // Registers at their extremes, upper write bits ignored on byte registers
    task automatic test_register_extremes();
        write_reg(hcid_pkg::CFG_START_BYTE, 16'h0000);
        write_reg(hcid_pkg::CFG_END_BYTE, 16'hFFFF);
        write_reg(hcid_pkg::CFG_ACK_TYPE, 16'h0000);
        repeat (6) send_random_frame(8);
        wait_idle();
        write_reg(hcid_pkg::CFG_START_BYTE, 16'hFFFF);
        write_reg(hcid_pkg::CFG_END_BYTE, 16'h0000);
        write_reg(hcid_pkg::CFG_ACK_TYPE, 16'hFFFF);
        repeat (6) send_random_frame(8);
        wait_idle();
    endtask

    // Receiver holds off while a long data frame keeps coming
    task automatic test_backpressure();
        logic [7:0] body[$];
        repeat (40) body.insert(body.size(), 8'($urandom));
        hold_off_left = 150;
        send_frame(~ack_type_val, 16'd40, body, 1'b0, end_val);
        wait_idle();
    endtask

    // Random frames and noise over several register settings; last phase without idling
    task automatic test_random_traffic();
        int unsigned target;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == RANDOM_PHASES - 1)
                idle_on = 1'b0;
            write_reg(hcid_pkg::CFG_START_BYTE, 16'($urandom));
            write_reg(hcid_pkg::CFG_END_BYTE, 16'($urandom));
            write_reg(hcid_pkg::CFG_ACK_TYPE, 16'($urandom));
            target = sent_count + RANDOM_BYTES / RANDOM_PHASES;
            while (sent_count < target) begin
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) send_byte(noise_byte());
                send_random_frame(48);
            end
            wait_idle();
        end
    endtask

    // Receiver: random stall bursts and the long hold-off
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_left > 0) begin
                hold_off_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 8);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    // Compare each accepted result item with the oldest prediction
    always @(posedge aclk) begin
        deframe_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with none expected: kind %0d data %0h",
                       m_kind, m_data_byte);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", 16'(want.kind), 16'(m_kind));
                check_field("frame_kind_code", want.frame_kind_code, m_frame_kind_code);
                check_field("data_byte", 16'(want.data_byte), 16'(m_data_byte));
                check_field("ack_request_type", want.ack_request_type, m_ack_request_type);
                check_field("ack_status", 16'(want.ack_status), 16'(m_ack_status));
                check_field("check_ok", 16'(want.check_ok), 16'(m_check_ok));
                check_field("frame_end", 16'(want.frame_end), 16'(m_frame_end));
            end
        end
    end

    // Test sequence
    initial begin
        s_valid       <= 1'b0;
        s_rx_byte     <= '0;
        cfg_wr_en     <= 1'b0;
        cfg_addr      <= hcid_pkg::CFG_START_BYTE;
        cfg_wdata     <= '0;
        aresetn       <= 1'b0;
        error_count   = 0;
        sent_count    = 0;
        hold_off_left = 0;
        idle_on       = 1'b1;
        clear_model();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_mid_frame_writes();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();

        if (pending_results.size() != 0) begin
            $error("%0d result items never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("tb_hci_uart_frame_deframer OK");
        else
            $display("tb_hci_uart_frame_deframer NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
